[src/gns_pkg.sv]
// Shared types, codes and the gate evaluation function of the gate netlist simulator.
// No dependencies; the simulator, gate table and value store refer to it by scoped names.
`default_nettype none

package gns_pkg;

  localparam int NODE_COUNT_DEF = 256;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    GK_NONE = 4'd0,
    GK_AND  = 4'd1,
    GK_OR   = 4'd2,
    GK_NAND = 4'd3,
    GK_NOR  = 4'd4,
    GK_NOT  = 4'd5,
    GK_XOR  = 4'd6,
    GK_XNOR = 4'd7,
    GK_BUF  = 4'd8
  } gate_kind_t;

  localparam logic RES_READ = 1'b0;
  localparam logic RES_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] src_c;
    logic [7:0] src_b;
    logic [7:0] src_a;
  } gate_entry_t;

  // Control of the value banks: write port and current-bank select for reads.
  typedef struct packed {
    logic wr_en;
    logic wr_all;
    logic wr_bank;
    logic wr_data;
    logic rd_bank;
  } val_ctl_t;

  function automatic logic gate_eval(logic [3:0] kind, logic a, logic b, logic c);
    logic res;
    unique case (kind)
      GK_AND:  res = a & b & c;
      GK_OR:   res = a | b | c;
      GK_NAND: res = ~(a & b & c);
      GK_NOR:  res = ~(a | b | c);
      GK_NOT:  res = ~a;
      GK_XOR:  res = a ^ b ^ c;
      GK_XNOR: res = ~(a ^ b ^ c);
      GK_BUF:  res = a;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[src/gns_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Plain payload fields; no dependencies.
`default_nettype none

interface gns_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] node_index;
  logic [3:0] gate_kind;
  logic [7:0] source_a;
  logic [7:0] source_b;
  logic [7:0] source_c;

  modport source (output valid, func, node_index, gate_kind, source_a, source_b, source_c,
                  input ready);
  modport sink (input valid, func, node_index, gate_kind, source_a, source_b, source_c,
                output ready);
endinterface

interface gns_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        node_value;
  logic [31:0] step_number;

  modport source (output valid, result_kind, node_value, step_number, input ready);
  modport sink (input valid, result_kind, node_value, step_number, output ready);
endinterface

`default_nettype wire

[src/gate_netlist_cycle_simulator.sv]
// Cycle-based gate netlist simulator: sequencer, evaluation pipeline and result register.
// Depends on gns_pkg, gns_if, gns_gate_table and gns_value_store.
//
// Usage:
//   req carries one item per transfer: func selects load (write a gate entry),
//   tick (evaluate every node once) or read (return a node's value). rsp carries
//   one result per tick or read; loads and unknown func codes give none.
//   Nodes 0 and 1 are the constants 0 and 1; loads to them are dropped.
// Timing:
//   A load writes the gate table on its transfer. A read passes through RDWAIT and DONE.
//   A tick walks nodes 2 to NODE_COUNT-1 through an evaluation pipeline around
//   one shared gate evaluator, one node per cycle; the gate table read port and
//   the value bank read ports set this rate.
//   req.ready is high only while the block is idle.
// Reset:
//   rst (synchronous) starts a clearing pass over every node address that zeroes the
//   gate table and both value banks; req.ready stays low until it ends.
// Stalls:
//   A finished result moves to the output register when that register is empty or
//   rsp.ready is high; until then the block waits in DONE and does not return to idle.
`default_nettype none

module gate_netlist_cycle_simulator #(
  parameter int NODE_COUNT = gns_pkg::NODE_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  gns_req_if.sink    req,
  gns_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NODE_COUNT - 1);

  function automatic logic node_live(logic [7:0] n);
    return (n >= 8'd2) && (32'(n) < 32'(NODE_COUNT));
  endfunction

  gns_pkg::state_t state;
  gns_pkg::state_t state_next;
  logic [IDX_W-1:0] cnt;
  logic             bank_sel;
  logic [31:0]      step_cnt;

  logic             req_fire;
  logic             out_load;

  logic                 tbl_wr_en;
  logic [IDX_W-1:0]     tbl_wr_addr;
  gns_pkg::gate_entry_t tbl_wr_entry;
  gns_pkg::gate_entry_t tbl_q;

  gns_pkg::val_ctl_t vs_ctl;
  logic [IDX_W-1:0]  vs_wr_addr;
  logic [IDX_W-1:0]  vs_rd_addr [3];
  logic              vs_data [3];

  logic             p1_valid;
  logic [IDX_W-1:0] p1_idx;
  logic             p2_valid;
  logic [IDX_W-1:0] p2_idx;
  logic [3:0]       p2_kind;
  logic [2:0]       p2_use;
  logic [2:0]       p2_one;
  logic             eval_res;

  logic rd_use;
  logic rd_one;
  logic pend_kind;
  logic pend_value;

  logic        out_valid;
  logic        out_kind;
  logic        out_value;
  logic [31:0] out_step;

  gns_gate_table #(.NODE_COUNT(NODE_COUNT)) u_table (
    .clk      (clk),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_wr_addr),
    .wr_entry (tbl_wr_entry),
    .rd_addr  (cnt),
    .rd_entry (tbl_q)
  );

  gns_value_store #(.NODE_COUNT(NODE_COUNT)) u_values (
    .clk     (clk),
    .ctl     (vs_ctl),
    .wr_addr (vs_wr_addr),
    .rd_addr (vs_rd_addr),
    .rd_data (vs_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gns_pkg::ST_CLEAR: begin
        if (cnt == IDX_LAST) state_next = gns_pkg::ST_IDLE;
      end
      gns_pkg::ST_IDLE: begin
        if (req_fire && req.func == gns_pkg::FUNC_TICK) begin
          state_next = gns_pkg::ST_TICK;
        end else if (req_fire && req.func == gns_pkg::FUNC_READ) begin
          state_next = gns_pkg::ST_RDWAIT;
        end
      end
      gns_pkg::ST_TICK: begin
        if (cnt == IDX_LAST) state_next = gns_pkg::ST_DRAIN;
      end
      gns_pkg::ST_DRAIN: begin
        if (!p1_valid && !p2_valid) state_next = gns_pkg::ST_DONE;
      end
      gns_pkg::ST_RDWAIT: begin
        state_next = gns_pkg::ST_DONE;
      end
      gns_pkg::ST_DONE: begin
        if (out_load) state_next = gns_pkg::ST_IDLE;
      end
      default: state_next = gns_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready = (state == gns_pkg::ST_IDLE);
    req_fire  = req.valid && req.ready;
    out_load  = (state == gns_pkg::ST_DONE) && (!out_valid || rsp.ready);

    tbl_wr_en    = 1'b0;
    tbl_wr_addr  = IDX_W'(req.node_index);
    tbl_wr_entry = '{kind: req.gate_kind, src_c: req.source_c,
                     src_b: req.source_b, src_a: req.source_a};
    if (state == gns_pkg::ST_CLEAR) begin
      tbl_wr_en    = 1'b1;
      tbl_wr_addr  = cnt;
      tbl_wr_entry = '0;
    end else if (req_fire && req.func == gns_pkg::FUNC_LOAD && node_live(req.node_index)) begin
      tbl_wr_en = 1'b1;
    end

    vs_rd_addr[0] = req.ready ? IDX_W'(req.node_index) : IDX_W'(tbl_q.src_a);
    vs_rd_addr[1] = IDX_W'(tbl_q.src_b);
    vs_rd_addr[2] = IDX_W'(tbl_q.src_c);

    eval_res = gns_pkg::gate_eval(p2_kind,
                                  p2_use[0] ? vs_data[0] : p2_one[0],
                                  p2_use[1] ? vs_data[1] : p2_one[1],
                                  p2_use[2] ? vs_data[2] : p2_one[2]);

    vs_ctl.rd_bank = bank_sel;
    vs_ctl.wr_bank = ~bank_sel;
    if (state == gns_pkg::ST_CLEAR) begin
      vs_ctl.wr_en   = 1'b1;
      vs_ctl.wr_all  = 1'b1;
      vs_ctl.wr_data = 1'b0;
      vs_wr_addr     = cnt;
    end else begin
      vs_ctl.wr_en   = p2_valid;
      vs_ctl.wr_all  = 1'b0;
      vs_ctl.wr_data = eval_res;
      vs_wr_addr     = p2_idx;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gns_pkg::ST_CLEAR;
      cnt      <= '0;
      bank_sel <= 1'b0;
      step_cnt <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= (state == gns_pkg::ST_TICK);
      p2_valid <= p1_valid;
      if (state == gns_pkg::ST_CLEAR || state == gns_pkg::ST_TICK) begin
        cnt <= cnt + 1'b1;
      end else if (state == gns_pkg::ST_IDLE) begin
        cnt <= IDX_FIRST;
      end
      if (out_load && pend_kind == gns_pkg::RES_TICK) begin
        bank_sel <= ~bank_sel;
        step_cnt <= step_cnt + 32'd1;
      end
    end
  end

  // Evaluation pipeline payload: stage 1 holds the node, stage 2 its decoded operands
  always_ff @(posedge clk) begin
    p1_idx    <= cnt;
    p2_idx    <= p1_idx;
    p2_kind   <= tbl_q.kind;
    p2_use[0] <= node_live(tbl_q.src_a);
    p2_use[1] <= node_live(tbl_q.src_b);
    p2_use[2] <= node_live(tbl_q.src_c);
    p2_one[0] <= (tbl_q.src_a == 8'd1);
    p2_one[1] <= (tbl_q.src_b == 8'd1);
    p2_one[2] <= (tbl_q.src_c == 8'd1);
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (req_fire) begin
      pend_kind  <= (req.func == gns_pkg::FUNC_TICK) ? gns_pkg::RES_TICK : gns_pkg::RES_READ;
      pend_value <= 1'b0;
      rd_use     <= node_live(req.node_index);
      rd_one     <= (req.node_index == 8'd1);
    end else if (state == gns_pkg::ST_RDWAIT) begin
      pend_value <= rd_use ? vs_data[0] : rd_one;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind  <= pend_kind;
      out_value <= pend_value;
      out_step  <= (pend_kind == gns_pkg::RES_TICK) ? step_cnt : 32'd0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.node_value  = out_value;
  assign rsp.step_number = out_step;

  // The evaluation pipeline only carries nodes during a tick.
  assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> (state == gns_pkg::ST_TICK || state == gns_pkg::ST_DRAIN))
    else $error("pipeline busy outside a tick");

  // Accepting a new item requires an empty pipeline.
  assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!p1_valid && !p2_valid))
    else $error("ready with nodes in flight");

  // A bank swap always comes with one step of the counter.
  assert property (@(posedge clk) disable iff (rst)
    (bank_sel != $past(bank_sel)) |-> (step_cnt == $past(step_cnt) + 32'd1))
    else $error("bank swap without step advance");

endmodule

`default_nettype wire

[src/gns_gate_table.sv]
// Gate table memory: kind and three source numbers per node, one write and one
// registered read port. Depends on gns_pkg.
`default_nettype none

module gns_gate_table #(
  parameter int NODE_COUNT = gns_pkg::NODE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0]     wr_addr,
  input  gns_pkg::gate_entry_t              wr_entry,
  input  logic [$clog2(NODE_COUNT)-1:0]     rd_addr,
  output gns_pkg::gate_entry_t              rd_entry
);

  gns_pkg::gate_entry_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/gns_value_store.sv]
// Double-buffered node value banks. Each bank is kept in three copies so the
// three gate operands read in the same cycle; read data is registered. Depends on gns_pkg.
`default_nettype none

module gns_value_store #(
  parameter int NODE_COUNT = gns_pkg::NODE_COUNT_DEF
) (
  input  logic                              clk,
  input  gns_pkg::val_ctl_t                 ctl,
  input  logic [$clog2(NODE_COUNT)-1:0]     wr_addr,
  input  logic [$clog2(NODE_COUNT)-1:0]     rd_addr [3],
  output logic                              rd_data [3]
);

  logic rd_bank_q;

  always_ff @(posedge clk) begin
    rd_bank_q <= ctl.rd_bank;
  end

  for (genvar r = 0; r < 3; r++) begin : g_copy
    logic bank0 [NODE_COUNT];
    logic bank1 [NODE_COUNT];
    logic q0;
    logic q1;

    always_ff @(posedge clk) begin
      if (ctl.wr_en && (ctl.wr_all || !ctl.wr_bank)) begin
        bank0[wr_addr] <= ctl.wr_data;
      end
      q0 <= bank0[rd_addr[r]];
    end

    always_ff @(posedge clk) begin
      if (ctl.wr_en && (ctl.wr_all || ctl.wr_bank)) begin
        bank1[wr_addr] <= ctl.wr_data;
      end
      q1 <= bank1[rd_addr[r]];
    end

    assign rd_data[r] = rd_bank_q ? q1 : q0;
  end

endmodule

`default_nettype wire
